// ----- rtl/core/efcs_pkg.sv -----
// Shared types, constants and the CRC-32/XFER fold function for the event frame serializer.
// No dependencies.
`default_nettype none

package efcs_pkg;

  localparam logic [31:0] CRC_POLY = 32'h0000_00AF;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_BYTES = 6;
  localparam int unsigned IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_SAMPLE,
    KIND_LAST
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [47:0]  data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // folds low byte then high byte, MSB-first
  function automatic logic [31:0] crc_fold16(input logic [31:0] crc_in,
                                             input logic [15:0] word);
    logic [31:0] c;
    c = crc_in;
    for (int b = 0; b < 2; b++) begin
      c = c ^ {word[b*8 +: 8], 24'd0};
      for (int k = 0; k < 8; k++) begin
        if (c[31]) begin
          c = {c[30:0], 1'b0} ^ CRC_POLY;
        end else begin
          c = {c[30:0], 1'b0};
        end
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/efcs_front.sv -----
// Front end: takes input words, keeps the running CRC and the enable register,
// and builds byte-run entries for the queue. Depends on efcs_pkg.
`default_nettype none

module efcs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic [31:0]        event_time,
  input  wire logic [15:0]        trigger_bits,
  input  wire logic [15:0]        sample_value,
  input  wire logic               last_sample,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,
  input  wire efcs_pkg::q_status_t q_status,
  output logic                    push,
  output efcs_pkg::entry_t        push_entry
);
  import efcs_pkg::*;

  logic        crc_enable;
  logic [31:0] running_crc;
  logic [31:0] running_crc_next;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;
  assign take      = in_valid && !q_status.full;
  assign push      = take;

  always_comb begin
    if (req_type == 1'b0) begin
      running_crc_next = '0;
    end else if (crc_enable) begin
      running_crc_next = crc_fold16(running_crc, sample_value);
    end else begin
      running_crc_next = running_crc;
    end
  end

  always_comb begin
    if (req_type == 1'b0) begin
      push_entry.kind = KIND_HEADER;
      push_entry.data = {trigger_bits, event_time};
    end else if (last_sample) begin
      push_entry.kind = KIND_LAST;
      push_entry.data = {running_crc_next, sample_value};
    end else begin
      push_entry.kind = KIND_SAMPLE;
      push_entry.data = {32'd0, sample_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_enable  <= 1'b1;
      running_crc <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        crc_enable <= cfg_data;
      end
      if (take) begin
        running_crc <= running_crc_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/efcs_queue.sv -----
// Short register queue of byte-run entries between front and back.
// Depends on efcs_pkg.
`default_nettype none

module efcs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire efcs_pkg::entry_t    push_entry,
  input  wire logic                pop,
  output efcs_pkg::entry_t         head,
  output efcs_pkg::q_status_t      q_status
);
  import efcs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == FULL_CNT);
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !pop)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/efcs_back.sv -----
// Back end: walks the head entry one byte per cycle into the output register while out_stall is low.
// Depends on efcs_pkg.
`default_nettype none

module efcs_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire efcs_pkg::entry_t    head,
  input  wire efcs_pkg::q_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_byte,
  output logic                     run_last,
  output logic                     frame_end
);
  import efcs_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             emit;
  logic             is_last_byte;
  logic             byte_run_last;
  logic             byte_frame_end;
  logic [7:0]       sel_byte;

  assign load = !out_valid || !out_stall;
  assign emit = load && !q_status.empty;

  always_comb begin
    case (idx)
      3'd0:    sel_byte = head.data[7:0];
      3'd1:    sel_byte = head.data[15:8];
      3'd2:    sel_byte = head.data[23:16];
      3'd3:    sel_byte = head.data[31:24];
      3'd4:    sel_byte = head.data[39:32];
      3'd5:    sel_byte = head.data[47:40];
      default: sel_byte = '0;
    endcase
  end

  always_comb begin
    byte_frame_end = 1'b0;
    case (head.kind)
      KIND_HEADER: begin
        is_last_byte  = (idx == IDX_W'(WORD_BYTES - 1));
        byte_run_last = is_last_byte;
      end
      KIND_SAMPLE: begin
        is_last_byte  = (idx == 3'd1);
        byte_run_last = is_last_byte;
      end
      KIND_LAST: begin
        is_last_byte   = (idx == IDX_W'(WORD_BYTES - 1));
        byte_run_last  = is_last_byte;
        byte_frame_end = is_last_byte;
      end
      default: begin
        is_last_byte  = 1'b1;
        byte_run_last = 1'b0;
      end
    endcase
  end

  assign pop = emit && is_last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (emit) begin
        idx <= is_last_byte ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= sel_byte;
      run_last  <= byte_run_last;
      frame_end <= byte_frame_end;
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx < IDX_W'(WORD_BYTES))
    else $error("byte index out of range");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(idx))
    else $error("byte index moved under stall");
  a_frame_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last)
    else $error("frame end without run last");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/event_frame_crc32_serializer.sv -----
// Top level of the event frame serializer with CRC-32/XFER.
// Depends on efcs_pkg, efcs_front, efcs_queue, efcs_back.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid / in_stall       req_type, event_time, trigger_bits,
//                                           sample_value, last_sample
//   out      out  out_valid / out_stall     out_byte, run_last, frame_end
//   cfg      in   cfg_valid / cfg_ready     cfg_data (crc_enable)
//
// One byte leaves per cycle while out_stall is low: a sample is 2 bytes, a header or
// last sample 6, all through the single output byte register. A word is taken while the
// entry queue (QUEUE_DEPTH entries) has room. Reset empties the queue, clears
// the CRC and sets crc_enable; out_stall holds the output byte in place.
`default_nettype none

module event_frame_crc32_serializer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [31:0] event_time,
  input  wire logic [15:0] trigger_bits,
  input  wire logic [15:0] sample_value,
  input  wire logic        last_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import efcs_pkg::*;

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    head;
  logic      push;
  logic      pop;

  efcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .event_time   (event_time),
    .trigger_bits (trigger_bits),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  efcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  efcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

// ----- verif/event_frame_crc32_serializer_test.sv -----
// Self-checking testbench for event_frame_crc32_serializer: directed table, then random frames.
// Predicts every output byte by its own CRC-32/XFER model or a typed row; depends on RTL only.
`timescale 1ns / 1ps

module event_frame_crc32_serializer_test;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;
  localparam logic [31:0] XFER_POLY = 32'h0000_00AF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_WORDS = 300;
  localparam int unsigned PLAN_ROWS = 19;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       frame_done;
  } frame_byte_t;

  // set_crc/crc_val: drain and write crc_enable before the word
  // typed: bytes holds the frame bytes low first, flags still come from the predictor
  typedef struct packed {
    logic        set_crc;
    logic        crc_val;
    logic        rq;
    logic [31:0] tstamp;
    logic [15:0] trig;
    logic [15:0] smp;
    logic        lst;
    logic        typed;
    logic [47:0] bytes;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{1'b1, 1'b1, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 48'h0},
    '{1'b0, 1'b0, REQ_HEADER, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF},
    '{1'b0, 1'b0, REQ_HEADER, 32'h0000_0000, 16'h0000, 16'hA5A5, 1'b1, 1'b1, 48'h0},
    '{1'b0, 1'b0, REQ_HEADER, 32'h1234_5678, 16'h9ABC, 16'h0000, 1'b0, 1'b1, 48'h9ABC_1234_5678},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001, 1'b0, 1'b0, 48'h0},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 48'h0},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'h8000, 1'b1, 1'b0, 48'h0},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'h1234, 1'b1, 1'b0, 48'h0},
    '{1'b1, 1'b0, REQ_HEADER, 32'hDEAD_BEEF, 16'h0F0F, 16'hFFFF, 1'b0, 1'b1, 48'h0F0F_DEAD_BEEF},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 48'h0000_0000_FFFF},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'hABCD, 1'b1, 1'b1, 48'h0000_0000_ABCD},
    '{1'b0, 1'b0, REQ_HEADER, 32'h0000_0001, 16'h8000, 16'h0000, 1'b0, 1'b1, 48'h8000_0000_0001},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'h5555, 1'b0, 1'b0, 48'h0},
    '{1'b1, 1'b1, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'hAAAA, 1'b0, 1'b0, 48'h0},
    '{1'b1, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'h0102, 1'b1, 1'b0, 48'h0},
    '{1'b1, 1'b1, REQ_HEADER, 32'h8000_0000, 16'h0001, 16'h0000, 1'b0, 1'b1, 48'h0001_8000_0000},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'h00FF, 1'b1, 1'b0, 48'h0},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'h0000_0000, 16'h0000, 16'hFF00, 1'b1, 1'b0, 48'h0},
    '{1'b0, 1'b0, REQ_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF, 1'b0, 1'b0, 48'h0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [31:0] event_time;
  logic [15:0] trigger_bits;
  logic [15:0] sample_value;
  logic        last_sample;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  logic [31:0] sum_crc;
  logic        crc_on;
  frame_byte_t frame_bytes [$];
  frame_byte_t want;
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct = 0;
  int unsigned words_sent;
  int unsigned fault_count;
  int unsigned idle_cycles;

  event_frame_crc32_serializer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .event_time   (event_time),
    .trigger_bits (trigger_bits),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] xfer_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ XFER_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  task automatic predict_frame_bytes(input logic rq, input logic [31:0] ts,
                                     input logic [15:0] trig, input logic [15:0] smp,
                                     input logic lst, input logic typed,
                                     input logic [47:0] typed_bytes);
    logic [47:0] bytes;
    int n;
    if (rq == REQ_HEADER) begin
      sum_crc = '0;
      bytes = {trig, ts};
      n = 6;
    end else begin
      if (crc_on) begin
        sum_crc = xfer_fold(xfer_fold(sum_crc, smp[7:0]), smp[15:8]);
      end
      bytes = {sum_crc, smp};
      n = lst ? 6 : 2;
    end
    if (typed) begin
      bytes = typed_bytes;
    end
    for (int k = 0; k < n; k++) begin
      frame_bytes.push_back('{bytes[8*k +: 8], k == n - 1,
                              rq == REQ_SAMPLE && lst && k == n - 1});
    end
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic rq, input logic [31:0] ts, input logic [15:0] trig,
                           input logic [15:0] smp, input logic lst, input logic typed,
                           input logic [47:0] typed_bytes);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= rq;
    event_time   <= ts;
    trigger_bits <= trig;
    sample_value <= smp;
    last_sample  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_bytes(rq, ts, trig, smp, lst, typed, typed_bytes);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input logic rq, input logic lst);
    send_word(rq, $urandom, 16'($urandom_range(65535)), 16'($urandom_range(65535)), lst,
              1'b0, 48'h0);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (frame_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic write_crc_enable(input logic en);
    drain_words();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    crc_on = en;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (frame_bytes.size() == 0) begin
          fault_count++;
          $error("out_byte: expected nothing, got %h", out_byte);
        end else begin
          want = frame_bytes.pop_front();
          if (out_byte !== want.data) begin
            fault_count++;
            $error("out_byte: expected %h, got %h", want.data, out_byte);
          end
          if (run_last !== want.run_end) begin
            fault_count++;
            $error("run_last: expected %b, got %b", want.run_end, run_last);
          end
          if (frame_end !== want.frame_done) begin
            fault_count++;
            $error("frame_end: expected %b, got %b", want.frame_done, frame_end);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned n_samples;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_HEADER;
    event_time   = '0;
    trigger_bits = '0;
    sample_value = '0;
    last_sample  = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    sum_crc      = '0;
    crc_on       = 1'b1;
    words_sent   = 0;
    fault_count  = 0;
    idle_cycles  = 0;
    snd_idle_pct = 26;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rcv_stall_pct = 77;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].set_crc) begin
        write_crc_enable(PLAN[i].crc_val);
      end
      send_word(PLAN[i].rq, PLAN[i].tstamp, PLAN[i].trig, PLAN[i].smp, PLAN[i].lst,
                PLAN[i].typed, PLAN[i].bytes);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 26;
          rcv_stall_pct = 77;
        end
        1: begin
          snd_idle_pct = 77;
          rcv_stall_pct = 26;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
      endcase
      write_crc_enable(phase != 1);
      target = words_sent + RANDOM_WORDS / 3;
      while (words_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          send_random(REQ_HEADER, 1'($urandom_range(1)));
          n_samples = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(5);
          repeat (n_samples) begin
            send_random(REQ_SAMPLE, 1'b0);
            if ($urandom_range(24) == 0) begin
              write_crc_enable(1'($urandom_range(1)));
            end
          end
          send_random(REQ_SAMPLE, 1'b1);
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 3)) send_random(REQ_SAMPLE, 1'($urandom_range(1)));
        end else begin
          send_random(REQ_HEADER, 1'($urandom_range(1)));
        end
        if ($urandom_range(5) == 0) begin
          write_crc_enable(1'($urandom_range(1)));
        end
      end
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && frame_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/efcs_pkg.sv
rtl/core/efcs_front.sv
rtl/core/efcs_queue.sv
rtl/core/efcs_back.sv
rtl/core/event_frame_crc32_serializer.sv
verif/event_frame_crc32_serializer_test.sv
